[rtl/gbcb_pkg.sv]
package gbcb_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 4;
    localparam int HEIGHT_LIMIT   = 1024;
    localparam int KERNEL_CAP     = 4;
    localparam int CW             = 12;   // raster coordinate width
    localparam int SW             = 14;   // signed coordinate width
    localparam int NCOEF          = 5;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx REG_RADIUS = 3'd0;
    localparam t_cfg_idx REG_WIDTH  = 3'd1;
    localparam t_cfg_idx REG_HEIGHT = 3'd2;
    localparam t_cfg_idx REG_COEF0  = 3'd3;
    localparam t_cfg_idx REG_COEF1  = 3'd4;
    localparam t_cfg_idx REG_COEF2  = 3'd5;
    localparam t_cfg_idx REG_COEF3  = 3'd6;
    localparam t_cfg_idx REG_COEF4  = 3'd7;

    typedef logic [NCOEF-1:0][15:0] t_coefs;
    typedef logic signed [SW-1:0] t_scoord;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_COL,
        ST_OFFS,
        ST_FIX,
        ST_MACV,
        ST_MACH,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic start;
        logic col_start;
        logic offs;
        logic fix;
        logic mac_v;
        logic mac_h;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic addr_ok;
        logic dy_last;
        logic dx_last;
        logic out_free;
    } t_sts;

    // copy border: q<0 reads q+r, q>=n reads q-r, then clamp into the image
    function automatic t_scoord border_map(input t_scoord q, input t_scoord n,
                                           input t_scoord r);
        t_scoord v;
        v = q;
        if (q < 0) begin
            v = q + r;
        end else if (q >= n) begin
            v = q - r;
        end
        if (v < 0) begin
            v = '0;
        end
        if (v > n - t_scoord'(1)) begin
            v = n - t_scoord'(1);
        end
        return v;
    endfunction

    function automatic logic [15:0] tap_weight(input logic signed [3:0] d,
                                               input t_coefs c);
        logic [3:0] a;
        a = (d < 0) ? 4'(-d) : 4'(d);
        if (a > 4'(KERNEL_CAP)) begin
            return 16'd0;
        end
        return c[a[2:0]];
    endfunction

endpackage

[rtl/gbcb_ctrl.sv]
module gbcb_ctrl
    import gbcb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_sts.emit) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_COL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_COL: begin
                o_cmd.col_start = 1'b1;
                n_state         = ST_OFFS;
            end
            ST_OFFS: begin
                o_cmd.offs = 1'b1;
                n_state    = ST_FIX;
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                if (i_sts.addr_ok) begin
                    n_state = ST_MACV;
                end
            end
            ST_MACV: begin
                o_cmd.mac_v = 1'b1;
                n_state     = i_sts.dy_last ? ST_MACH : ST_OFFS;
            end
            ST_MACH: begin
                o_cmd.mac_h = 1'b1;
                n_state     = i_sts.dx_last ? ST_FINISH : ST_COL;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/gbcb_datapath.sv]
module gbcb_datapath
    import gbcb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_action,
    input  logic [7:0]  i_chan_a,
    input  logic [7:0]  i_chan_b,
    input  logic [7:0]  i_chan_c,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_a,
    output logic [7:0]  o_out_b,
    output logic [7:0]  o_out_c,
    output logic        o_frame_end
);

    localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
    localparam int AWD   = $clog2(DEPTH);
    localparam int PDW   = $clog2(DEPTH + 1);
    localparam int LTW   = 14;
    localparam int CMPW  = ((PDW > LTW) ? PDW : LTW) + 1;
    localparam int AW    = 30;
    localparam int CSW   = 28;
    localparam int TOW   = 48;

    logic [2:0]  r_radius;
    logic [10:0] r_width;
    logic [10:0] r_height;
    t_coefs      r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 3'd3;
            r_width  <= 11'd640;
            r_height <= 11'd480;
            r_coef   <= {16'd0, 16'd291, 16'd3540, 16'd15862, 16'd26152};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RADIUS: r_radius  <= i_cfg_data[2:0];
                REG_WIDTH:  r_width   <= i_cfg_data[10:0];
                REG_HEIGHT: r_height  <= i_cfg_data[10:0];
                REG_COEF0:  r_coef[0] <= i_cfg_data;
                REG_COEF1:  r_coef[1] <= i_cfg_data;
                REG_COEF2:  r_coef[2] <= i_cfg_data;
                REG_COEF3:  r_coef[3] <= i_cfg_data;
                REG_COEF4:  r_coef[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [2:0]    eff_r;
    logic [10:0]   w0;
    logic [10:0]   h0;
    logic [CW-1:0] w_eff;
    logic [CW-1:0] h_eff;
    logic signed [3:0] eff_rs;

    always_comb begin
        eff_r = r_radius;
        if (int'(eff_r) > MAX_RADIUS) begin
            eff_r = 3'(MAX_RADIUS);
        end
        if (int'(eff_r) > KERNEL_CAP) begin
            eff_r = 3'(KERNEL_CAP);
        end
        w0    = (r_width == '0) ? 11'd1 : r_width;
        h0    = (r_height == '0) ? 11'd1 : r_height;
        w_eff = (int'(w0) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(w0);
        h_eff = (int'(h0) > HEIGHT_LIMIT) ? CW'(HEIGHT_LIMIT) : CW'(h0);
    end

    assign eff_rs = $signed({1'b0, eff_r});

    // stream state
    logic [23:0]    mem [DEPTH];
    logic [23:0]    r_rd;
    logic [AWD-1:0] r_wr_ptr;
    logic [PDW-1:0] r_pending;
    logic           r_action;
    logic [CW-1:0]  r_out_row;
    logic [CW-1:0]  r_out_col;
    logic           r_valid;

    logic signed [AW-1:0] r_base;
    logic signed [AW-1:0] r_addr;
    logic signed [3:0]    r_dx;
    logic signed [3:0]    r_dy;
    t_scoord              r_dcol;
    logic [2:0][CSW-1:0]  r_colsum;
    logic [2:0][TOW-1:0]  r_total;

    logic [LTW-1:0] latency;
    logic           addr_ok;
    logic           wr_pix;
    t_scoord        q_col;
    t_scoord        q_row;
    t_scoord        bm_col;
    t_scoord        bm_row;
    t_scoord        drow;
    logic signed [SW+CW:0] off_row;
    logic [15:0]    wv;
    logic [15:0]    wh;

    assign latency = LTW'(eff_r) * LTW'(w_eff) + LTW'(eff_r);
    assign addr_ok = (r_addr >= 0) && (r_addr < AW'(DEPTH));
    assign wr_pix  = i_cmd.accept && !i_action;

    assign q_col  = $signed({2'b00, r_out_col}) + SW'(r_dx);
    assign q_row  = $signed({2'b00, r_out_row}) + SW'(r_dy);
    assign bm_col = border_map(q_col, $signed({2'b00, w_eff}), SW'(eff_rs));
    assign bm_row = border_map(q_row, $signed({2'b00, h_eff}), SW'(eff_rs));
    assign drow   = bm_row - $signed({2'b00, r_out_row});
    assign off_row = drow * $signed({1'b0, w_eff});
    assign wv = tap_weight(r_dy, r_coef);
    assign wh = tap_weight(r_dx, r_coef);

    assign o_sts.emit     = r_action ? (r_pending != '0)
                                     : (CMPW'(r_pending) > CMPW'(latency));
    assign o_sts.addr_ok  = addr_ok;
    assign o_sts.dy_last  = (r_dy == eff_rs);
    assign o_sts.dx_last  = (r_dx == eff_rs);
    assign o_sts.out_free = !r_valid || i_ready;

    // line store: one write port for incoming pixels, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_pix) begin
            mem[r_wr_ptr] <= {i_chan_c, i_chan_b, i_chan_a};
        end
        if (i_cmd.fix && addr_ok) begin
            r_rd <= mem[r_addr[AWD-1:0]];
        end
    end

    // window walk and accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_action;
        end
        if (i_cmd.start) begin
            r_base  <= AW'($signed({1'b0, r_wr_ptr})) - AW'($signed({1'b0, r_pending}));
            r_dx    <= -eff_rs;
            r_total <= '0;
        end
        if (i_cmd.col_start) begin
            r_dy     <= -eff_rs;
            r_colsum <= '0;
            r_dcol   <= bm_col - $signed({2'b00, r_out_col});
        end
        if (i_cmd.offs) begin
            r_addr <= r_base + AW'(off_row) + AW'(r_dcol);
        end
        if (i_cmd.fix && !addr_ok) begin
            if (r_addr < 0) begin
                r_addr <= r_addr + AW'(DEPTH);
            end else begin
                r_addr <= r_addr - AW'(DEPTH);
            end
        end
        if (i_cmd.mac_v) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_colsum[ch] <= r_colsum[ch] + CSW'(r_rd[8*ch +: 8]) * CSW'(wv);
            end
            r_dy <= r_dy + 4'sd1;
        end
        if (i_cmd.mac_h) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_total[ch] <= r_total[ch] + TOW'(r_colsum[ch]) * TOW'(wh);
            end
            r_dx <= r_dx + 4'sd1;
        end
    end

    // round half up, then saturate
    function automatic logic [7:0] round_sat(input logic [TOW-1:0] t);
        logic [TOW:0]  s;
        logic [16:0]   v;
        s = {1'b0, t} + (TOW+1)'(64'h8000_0000);
        v = s[TOW:32];
        return (v > 17'd255) ? 8'd255 : v[7:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_out_a     <= round_sat(r_total[0]);
            o_out_b     <= round_sat(r_total[1]);
            o_out_c     <= round_sat(r_total[2]);
            o_frame_end <= (r_out_row == h_eff - 1'b1) && (r_out_col == w_eff - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_pending <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (wr_pix) begin
                r_wr_ptr <= (int'(r_wr_ptr) == DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
                if (int'(r_pending) < DEPTH) begin
                    r_pending <= r_pending + 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_valid   <= 1'b1;
                r_pending <= r_pending - 1'b1;
                if ({1'b0, r_out_col} + 1'b1 >= {1'b0, w_eff}) begin
                    r_out_col <= '0;
                    if ({1'b0, r_out_row} + 1'b1 >= {1'b0, h_eff}) begin
                        r_out_row <= '0;
                    end else begin
                        r_out_row <= r_out_row + 1'b1;
                    end
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;

`ifndef SYNTHESIS
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_pending) <= DEPTH)
        else $error("pending count beyond store depth");
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_valid || i_ready))
        else $error("result overwrote a waiting result");
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_valid)
        else $error("finished result not presented");
    a_wr_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_wr_ptr) < DEPTH)
        else $error("write pointer out of range");
`endif

endmodule

[rtl/gaussian_blur_copy_border.sv]
// Separable Gaussian blur over three 8-bit channels with a copy border.
// Input channel (i_valid/o_ready): one item per pixel in raster order, or a
// flush item (i_action = 1) that drains one pending result. Output channel
// (o_valid/i_ready): filtered pixels in raster order; o_frame_end marks the
// last pixel of the image. Configuration: write i_cfg_data to register
// i_cfg_idx when i_cfg_we is high (radius, width, height, five tap weights);
// write only while the block is idle.
// A result for pixel n leaves with the input item R*W+R positions later,
// or with a flush item. Each item is accepted and then decided on; an item
// that produces a result then walks the (2R+1)^2 window through the single
// read port of the line store (an offset, a fix and a vertical MAC step per
// tap, a column start and a horizontal MAC step per column), then loads the
// output register. Pixel addresses outside the ring take extra fix steps.
// Reset clears pointers, counters and the output valid flag and restores the
// default geometry and weights; the line store is not cleared.
// A finished result waits in the output register while the receiver stalls;
// the next item is accepted meanwhile and stalls only if it also finishes
// before the waiting result is taken.
module gaussian_blur_copy_border
    import gbcb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_chan_a,
    input  logic [7:0]  i_chan_b,
    input  logic [7:0]  i_chan_c,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_a,
    output logic [7:0]  o_out_b,
    output logic [7:0]  o_out_c,
    output logic        o_frame_end
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: accept, decide, walk the window, hand off the result
    gbcb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // line store, address walk, multiply-accumulate and output register
    gbcb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_action    (i_action),
        .i_chan_a    (i_chan_a),
        .i_chan_b    (i_chan_b),
        .i_chan_c    (i_chan_c),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_a     (o_out_a),
        .o_out_b     (o_out_b),
        .o_out_c     (o_out_c),
        .o_frame_end (o_frame_end)
    );

endmodule
